>>> rtl/core/gmlsu_pkg.sv
// Shared constants, action codes and inter-module structs for the guest memory
// load/store unit. No dependencies; imported by decode, merge and the top level.
`default_nettype none

package gmlsu_pkg;

    // Store sizes in bytes (powers of two)
    localparam int RAM_BYTES   = 65536;
    localparam int VIDEO_BYTES = 4096;

    localparam int RAM_AW     = $clog2(RAM_BYTES);
    localparam int VIDEO_AW   = $clog2(VIDEO_BYTES);
    localparam int RAM_ROWS   = RAM_BYTES / 4;
    localparam int VIDEO_ROWS = VIDEO_BYTES / 4;
    localparam int RAM_RW     = RAM_AW - 2;
    localparam int VIDEO_RW   = VIDEO_AW - 2;
    localparam int CLR_ROWS   = (RAM_ROWS > VIDEO_ROWS) ? RAM_ROWS : VIDEO_ROWS;
    localparam int CLR_W      = $clog2(CLR_ROWS);

    localparam int ADDR_W    = 29;
    localparam int SPAN_W    = 30;
    localparam int CFG_W     = 30;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_RAM_BASE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_VIDEO_BASE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_VIDEO_SPAN = 2'd2;

    localparam logic [ADDR_W-1:0] RAM_BASE_RST   = 29'h0800_0000;
    localparam logic [ADDR_W-1:0] VIDEO_BASE_RST = 29'h0400_0000;
    localparam logic [SPAN_W-1:0] VIDEO_SPAN_RST = 30'h0080_0000;

    localparam logic [31:0] LOW3_MASK  = 32'h00FF_FFFF;
    localparam logic [31:0] HIGH3_MASK = 32'hFFFF_FF00;

    typedef enum logic [3:0] {
        ACT_LD8  = 4'd0,
        ACT_LD16 = 4'd1,
        ACT_LD32 = 4'd2,
        ACT_LDL  = 4'd3,
        ACT_LDR  = 4'd4,
        ACT_ST8  = 4'd5,
        ACT_ST16 = 4'd6,
        ACT_ST32 = 4'd7,
        ACT_STL  = 4'd8,
        ACT_STR  = 4'd9
    } action_t;

    // Per-byte mapping of one access and per-lane row addresses
    typedef struct packed {
        logic                       fault;
        logic [3:0]                 vid;
        logic [3:0]                 ram;
        logic [3:0][1:0]            vlane;
        logic [3:0][1:0]            rlane;
        logic [3:0][VIDEO_RW-1:0]   vrow;
        logic [3:0][RAM_RW-1:0]     rrow;
    } dec_t;

    // Per-lane write-back of one access
    typedef struct packed {
        logic [3:0]       vwe;
        logic [3:0]       rwe;
        logic [3:0][7:0]  vwd;
        logic [3:0][7:0]  rwd;
    } wr_t;

endpackage

`default_nettype wire

>>> rtl/core/gmlsu_ram.sv
// Generic byte-wide simple dual-port RAM with a registered read.
// No dependencies.
`default_nettype none

module gmlsu_ram #(
    parameter int DEPTH = 1024,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic          clk,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire logic [7:0]    wdata,
    input  wire logic [AW-1:0] raddr,
    output logic      [7:0]    rdata
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

>>> rtl/core/gmlsu_decode.sv
// Address decode: canonicalize, map each byte of an access to video or main
// store, and derive per-lane row addresses. Depends on gmlsu_pkg.
`default_nettype none

module gmlsu_decode
    import gmlsu_pkg::*;
(
    input  wire action_t             action,
    input  wire logic [31:0]         address,
    input  wire logic [ADDR_W-1:0]   ram_base,
    input  wire logic [ADDR_W-1:0]   video_base,
    input  wire logic [SPAN_W-1:0]   video_span,
    output dec_t                     dec
);

    logic [3:0]              act;
    logic [ADDR_W-1:0]       base;
    logic [ADDR_W+1:0]       vend;
    logic [3:0][ADDR_W-1:0]  ci;
    logic [3:0][ADDR_W-1:0]  voff;
    logic [3:0][ADDR_W-1:0]  roff;
    logic [3:0]              vhit;
    logic [3:0]              rhit;
    logic [3:0][1:0]         vk;
    logic [3:0][1:0]         rk;

    always_comb
    begin
        act  = 4'b0000;
        base = address[ADDR_W-1:0];
        unique case (action) inside
            ACT_LD8, ACT_ST8:   act = 4'b0001;
            ACT_LD16, ACT_ST16: act = 4'b0011;
            ACT_LD32, ACT_ST32: act = 4'b1111;
            ACT_LDL, ACT_LDR, ACT_STL, ACT_STR:
            begin
                act  = 4'b1111;
                base = {address[ADDR_W-1:2], 2'b00};
            end
            default:            act = 4'b0000;
        endcase

        vend = {2'b00, video_base} + {1'b0, video_span};
        dec  = '0;

        for (int i = 0; i < 4; i++)
        begin
            ci[i]   = base + ADDR_W'(i);
            voff[i] = ci[i] - video_base;
            roff[i] = ci[i] - ram_base;
            vhit[i] = (ci[i] >= video_base) && ({2'b00, ci[i]} < vend);
            rhit[i] = !vhit[i] && (ci[i] >= ram_base) && (roff[i] < ADDR_W'(RAM_BYTES));
            dec.vid[i]   = act[i] & vhit[i];
            dec.ram[i]   = act[i] & rhit[i];
            dec.vlane[i] = voff[i][1:0];
            dec.rlane[i] = roff[i][1:0];
        end
        dec.fault = |(act & ~(vhit | rhit));

        for (int l = 0; l < 4; l++)
        begin
            vk[l] = 2'(l) - voff[0][1:0];
            rk[l] = 2'(l) - roff[0][1:0];
            dec.vrow[l] = voff[vk[l]][VIDEO_AW-1:2];
            dec.rrow[l] = roff[rk[l]][RAM_AW-1:2];
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/gmlsu_merge.sv
// Data path: gather the memory word from the byte lanes, form load results and
// merged store words, and steer store bytes to lanes. Depends on gmlsu_pkg.
`default_nettype none

module gmlsu_merge
    import gmlsu_pkg::*;
(
    input  wire action_t        action,
    input  wire logic [1:0]     addr_lo,
    input  wire logic [31:0]    write_data,
    input  wire logic [31:0]    existing_word,
    input  wire dec_t           dec,
    input  wire logic [3:0][7:0] vq,
    input  wire logic [3:0][7:0] rq,
    output logic      [31:0]    rd,
    output wr_t                 wr
);

    logic [31:0] mem;
    logic [31:0] w;
    logic [4:0]  sh;
    logic [4:0]  shl;
    logic        store;

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            mem[8*i +: 8] = dec.vid[i] ? vq[dec.vlane[i]] : rq[dec.rlane[i]];
        end
        sh    = {addr_lo, 3'b000};
        shl   = 5'd24 - sh;
        rd    = '0;
        w     = write_data;
        store = 1'b0;

        unique case (action) inside
            ACT_LD8:  rd = {24'b0, mem[7:0]};
            ACT_LD16: rd = {16'b0, mem[15:0]};
            ACT_LD32: rd = mem;
            ACT_LDL:  rd = (existing_word & (LOW3_MASK >> sh)) | (mem << shl);
            ACT_LDR:  rd = (existing_word & (HIGH3_MASK << shl)) | (mem >> sh);
            ACT_ST8, ACT_ST16, ACT_ST32: store = 1'b1;
            ACT_STL:
            begin
                store = 1'b1;
                w     = (write_data >> shl) | (mem & (HIGH3_MASK << sh));
            end
            ACT_STR:
            begin
                store = 1'b1;
                w     = (write_data << sh) | (mem & (LOW3_MASK >> shl));
            end
            default:  rd = '0;
        endcase

        if (dec.fault)
        begin
            rd = '0;
        end

        wr = '0;
        for (int l = 0; l < 4; l++)
        begin
            for (int i = 0; i < 4; i++)
            begin
                if (store && !dec.fault && dec.vid[i] && dec.vlane[i] == 2'(l))
                begin
                    wr.vwe[l] = 1'b1;
                    wr.vwd[l] = w[8*i +: 8];
                end
                if (store && !dec.fault && dec.ram[i] && dec.rlane[i] == 2'(l))
                begin
                    wr.rwe[l] = 1'b1;
                    wr.rwd[l] = w[8*i +: 8];
                end
            end
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/guest_memory_load_store_unit_core.sv
// Top level of the guest memory load/store unit: control sequencer, config
// registers and the byte-lane stores. Depends on gmlsu_pkg, gmlsu_ram,
// gmlsu_decode and gmlsu_merge.
//
// Usage:
//   Input stream s_*: one access per word; s_tuser carries the action code,
//   s_tdata the address, store data and the register value for left/right loads.
//   Output stream m_*: exactly one result word per access; m_tdata is the load
//   value (zero for stores and faults), m_tuser[0] is the fault flag.
//   Config port: cfg_wr_en/cfg_index/cfg_data write ram_base (0), video_base (1)
//   and video_span (2); write only while no access is in flight.
//   Sequence: m_tvalid rises once the merge step loads the result register. An
//   access passes decode and lane read, merge and write-back, and accept; the
//   byte-lane stores have a registered read. One access is in flight at a time.
//   Reset: the stores are swept to zero, one row of four bytes per cycle over
//   CLR_ROWS rows (16384 with the default sizes); s_tready stays low during
//   the sweep, config writes are taken as usual.
//   Stall: the result register holds while m_tready is low; the next access is
//   accepted meanwhile and waits in the merge step until the register frees.
`default_nettype none

module guest_memory_load_store_unit_core
    import gmlsu_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [95:0]           s_tdata,   // address, write_data, existing_word
    input  wire logic [3:0]            s_tuser,   // action
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic      [31:0]           m_tdata,   // read_data
    output logic      [0:0]            m_tuser,   // fault
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_W-1:0]      cfg_data
);

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DEC,
        ST_MRG
    } state_t;

    state_t              state_reg;
    logic [CLR_W-1:0]    clr_reg;
    logic                out_valid_reg;
    logic [31:0]         out_data_reg;
    logic                out_fault_reg;

    logic [ADDR_W-1:0]   ram_base_reg;
    logic [ADDR_W-1:0]   video_base_reg;
    logic [SPAN_W-1:0]   video_span_reg;

    action_t             action_reg;
    logic [31:0]         addr_reg;
    logic [31:0]         wd_reg;
    logic [31:0]         ex_reg;
    dec_t                dec_reg;

    dec_t                dec;
    wr_t                 wr;
    logic [31:0]         rd;
    logic                out_free;
    logic                mrg_go;
    logic                clearing;
    logic                vclr_en;

    logic [3:0][7:0]            vq;
    logic [3:0][7:0]            rq;
    logic [3:0]                 vwe;
    logic [3:0]                 rwe;
    logic [3:0][VIDEO_RW-1:0]   vwaddr;
    logic [3:0][RAM_RW-1:0]     rwaddr;
    logic [3:0][7:0]            vwdata;
    logic [3:0][7:0]            rwdata;

    assign s_tready   = (state_reg == ST_IDLE);
    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = out_data_reg;
    assign m_tuser[0] = out_fault_reg;
    assign out_free   = !out_valid_reg || m_tready;
    assign mrg_go     = (state_reg == ST_MRG) && out_free;
    assign clearing   = (state_reg == ST_CLEAR);
    assign vclr_en    = ({1'b0, clr_reg} < (CLR_W + 1)'(VIDEO_ROWS));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ram_base_reg   <= RAM_BASE_RST;
            video_base_reg <= VIDEO_BASE_RST;
            video_span_reg <= VIDEO_SPAN_RST;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_RAM_BASE:   ram_base_reg   <= cfg_data[ADDR_W-1:0];
                CFG_VIDEO_BASE: video_base_reg <= cfg_data[ADDR_W-1:0];
                CFG_VIDEO_SPAN: video_span_reg <= cfg_data[SPAN_W-1:0];
                default:        ram_base_reg   <= ram_base_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
            out_fault_reg <= 1'b0;
        end
        else
        begin
            if (mrg_go)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_CLEAR:
                begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == CLR_W'(CLR_ROWS - 1))
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        state_reg <= ST_DEC;
                    end
                end
                ST_DEC:
                begin
                    state_reg <= ST_MRG;
                end
                ST_MRG:
                begin
                    if (out_free)
                    begin
                        out_data_reg  <= rd;
                        out_fault_reg <= dec_reg.fault;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            action_reg <= action_t'(s_tuser);
            addr_reg   <= s_tdata[31:0];
            wd_reg     <= s_tdata[63:32];
            ex_reg     <= s_tdata[95:64];
        end
        if (state_reg == ST_DEC)
        begin
            dec_reg <= dec;
        end
    end

    gmlsu_decode u_decode (
        .action     (action_reg),
        .address    (addr_reg),
        .ram_base   (ram_base_reg),
        .video_base (video_base_reg),
        .video_span (video_span_reg),
        .dec        (dec)
    );

    gmlsu_merge u_merge (
        .action        (action_reg),
        .addr_lo       (addr_reg[1:0]),
        .write_data    (wd_reg),
        .existing_word (ex_reg),
        .dec           (dec_reg),
        .vq            (vq),
        .rq            (rq),
        .rd            (rd),
        .wr            (wr)
    );

    always_comb
    begin
        for (int l = 0; l < 4; l++)
        begin
            if (clearing)
            begin
                vwe[l]    = vclr_en;
                rwe[l]    = 1'b1;
                vwaddr[l] = clr_reg[VIDEO_RW-1:0];
                rwaddr[l] = clr_reg[RAM_RW-1:0];
                vwdata[l] = 8'h00;
                rwdata[l] = 8'h00;
            end
            else
            begin
                vwe[l]    = mrg_go && wr.vwe[l];
                rwe[l]    = mrg_go && wr.rwe[l];
                vwaddr[l] = dec_reg.vrow[l];
                rwaddr[l] = dec_reg.rrow[l];
                vwdata[l] = wr.vwd[l];
                rwdata[l] = wr.rwd[l];
            end
        end
    end

    for (genvar l = 0; l < 4; l++)
    begin : g_lane
        gmlsu_ram #(
            .DEPTH (VIDEO_ROWS)
        ) u_vram (
            .clk   (clk),
            .we    (vwe[l]),
            .waddr (vwaddr[l]),
            .wdata (vwdata[l]),
            .raddr (dec.vrow[l]),
            .rdata (vq[l])
        );

        gmlsu_ram #(
            .DEPTH (RAM_ROWS)
        ) u_mram (
            .clk   (clk),
            .we    (rwe[l]),
            .waddr (rwaddr[l]),
            .wdata (rwdata[l]),
            .raddr (dec.rrow[l]),
            .rdata (rq[l])
        );
    end

    a_fault_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MRG && dec_reg.fault) |-> (wr.vwe == 4'b0 && wr.rwe == 4'b0))
        else $error("faulting access drives a lane write");

    a_clear_no_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR) |-> !s_tready)
        else $error("input accepted during clearing sweep");

    a_fault_zero_data: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_fault_reg) |-> (out_data_reg == 32'b0))
        else $error("fault result carries nonzero data");

    a_single_region: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MRG) |-> ((dec_reg.vid & dec_reg.ram) == 4'b0))
        else $error("byte mapped to both stores");

    a_result_from_merge: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == ST_MRG))
        else $error("result loaded outside merge step");

endmodule

`default_nettype wire
